### hdl/ohm_pkg.sv
// types and constants shared by the hash map controller and datapath
package ohm_pkg;

   localparam int unsigned KEY_W = 64;
   localparam int unsigned VALUE_W = 64;
   localparam int unsigned SIZE_W = 9;
   localparam int unsigned HASH_W = 32;

   typedef enum logic [1:0] {
      KIND_ADD    = 2'd0,
      KIND_REMOVE = 2'd1,
      KIND_GET    = 2'd2,
      KIND_CLEAR  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_MISSING  = 2'd1,
      STATUS_FULL     = 2'd2,
      STATUS_RESERVED = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      SLOT_EMPTY   = 2'd0,
      SLOT_USED    = 2'd1,
      SLOT_DELETED = 2'd2,
      SLOT_UNUSED  = 2'd3
   } slot_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_CLEAR,
      ST_HASH,
      ST_MOD,
      ST_READ,
      ST_WAIT,
      ST_CHECK,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [KEY_W-1:0]   key_high;
      logic [KEY_W-1:0]   key_low;
      logic [VALUE_W-1:0] entry_value;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [VALUE_W-1:0] found_value;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load_req;
      logic hash_start;
      logic mod_step;
      logic probe_init;
      logic probe_next;
      logic sweep_init;
      logic sweep_next;
      logic sweep_write;
      logic write_add;
      logic write_delete;
      logic set_result;
      logic [1:0] result_status;
      logic take_value;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [1:0] kind;
      logic mod_done;
      logic sweep_last;
      logic probe_last;
      logic [1:0] slot_state;
      logic key_match;
   } stat_type;

endpackage

### hdl/open_addressing_hash_map.sv
// top level of the open addressing hash map
// add, remove and get hash the key, reduce it modulo the table size, then read, wait and check each probed slot
// one operation at a time: a new request is taken only once the last response is accepted
// clear: a pass over the slot status memory that marks every slot empty, then the response
// reset sets table_size to 256 and starts the state machine in that pass, then goes idle
module open_addressing_hash_map #(
   parameter int unsigned TABLE_DEPTH = 256,
   parameter int unsigned KEY_BYTES = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  ohm_pkg::req_type           req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output ohm_pkg::rsp_type           rsp_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [ohm_pkg::SIZE_W-1:0] csr_data
);

   ohm_pkg::cmd_type cmd;
   ohm_pkg::stat_type stat;

   assign csr_ready = 1'b1;

   ohm_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .stat(stat), .cmd(cmd));

   ohm_datapath #(.TABLE_DEPTH(TABLE_DEPTH), .KEY_BYTES(KEY_BYTES)) u_datapath (
      .clock(clock), .reset(reset), .req_data(req_data), .csr_valid(csr_valid),
      .csr_data(csr_data), .cmd(cmd), .stat(stat), .rsp_data(rsp_data));

   assert property (@(posedge clock) disable iff (reset) !(req_ready && rsp_valid))
      else $error("request taken while a response waits");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status != ohm_pkg::STATUS_RESERVED)
      else $error("reserved status code");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != ohm_pkg::STATUS_OK) |-> rsp_data.found_value == '0)
      else $error("value on failed operation");

endmodule

### hdl/ohm_ram.sv
// generic single port ram with registered read
module ohm_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

### hdl/ohm_ctrl.sv
// controller state machine for the hash map
module ohm_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  ohm_pkg::stat_type     stat,
   output ohm_pkg::cmd_type      cmd
);

   ohm_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ohm_pkg::ST_SWEEP;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ohm_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in = ohm_pkg::ST_HASH;
            end
         end
         ohm_pkg::ST_SWEEP: begin
            cmd.sweep_write = 1'b1;
            cmd.sweep_next = 1'b1;
            if (stat.sweep_last) begin
               state_in = ohm_pkg::ST_IDLE;
            end
         end
         ohm_pkg::ST_CLEAR: begin
            cmd.sweep_write = 1'b1;
            cmd.sweep_next = 1'b1;
            if (stat.sweep_last) begin
               state_in = ohm_pkg::ST_RESP;
            end
         end
         ohm_pkg::ST_HASH: begin
            cmd.hash_start = 1'b1;
            cmd.sweep_init = 1'b1;
            if (stat.kind == ohm_pkg::KIND_CLEAR) begin
               state_in = ohm_pkg::ST_CLEAR;
               cmd.set_result = 1'b1;
               cmd.result_status = ohm_pkg::STATUS_OK;
            end else begin
               state_in = ohm_pkg::ST_MOD;
            end
         end
         ohm_pkg::ST_MOD: begin
            cmd.mod_step = 1'b1;
            if (stat.mod_done) begin
               cmd.probe_init = 1'b1;
               state_in = ohm_pkg::ST_READ;
            end
         end
         ohm_pkg::ST_READ: begin
            state_in = ohm_pkg::ST_WAIT;
         end
         ohm_pkg::ST_WAIT: begin
            state_in = ohm_pkg::ST_CHECK;
         end
         ohm_pkg::ST_CHECK: begin
            state_in = ohm_pkg::ST_RESP;
            cmd.set_result = 1'b1;
            if (stat.kind == ohm_pkg::KIND_ADD) begin
               if (stat.slot_state != ohm_pkg::SLOT_USED) begin
                  cmd.write_add = 1'b1;
                  cmd.result_status = ohm_pkg::STATUS_OK;
               end else if (stat.probe_last) begin
                  cmd.result_status = ohm_pkg::STATUS_FULL;
               end else begin
                  cmd.set_result = 1'b0;
                  cmd.probe_next = 1'b1;
                  state_in = ohm_pkg::ST_READ;
               end
            end else begin
               if (stat.slot_state == ohm_pkg::SLOT_EMPTY) begin
                  cmd.result_status = ohm_pkg::STATUS_MISSING;
               end else if (stat.slot_state == ohm_pkg::SLOT_USED && stat.key_match) begin
                  cmd.result_status = ohm_pkg::STATUS_OK;
                  cmd.write_delete = (stat.kind == ohm_pkg::KIND_REMOVE);
                  cmd.take_value = (stat.kind == ohm_pkg::KIND_GET);
               end else if (stat.probe_last) begin
                  cmd.result_status = ohm_pkg::STATUS_MISSING;
               end else begin
                  cmd.set_result = 1'b0;
                  cmd.probe_next = 1'b1;
                  state_in = ohm_pkg::ST_READ;
               end
            end
         end
         ohm_pkg::ST_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = ohm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ohm_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

### hdl/ohm_datapath.sv
// hash, modulo, probe address, slot stores and result register
module ohm_datapath #(
   parameter int unsigned TABLE_DEPTH = 256,
   parameter int unsigned KEY_BYTES = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ohm_pkg::req_type              req_data,
   input  logic                          csr_valid,
   input  logic [ohm_pkg::SIZE_W-1:0]    csr_data,
   input  ohm_pkg::cmd_type              cmd,
   output ohm_pkg::stat_type             stat,
   output ohm_pkg::rsp_type              rsp_data
);

   localparam int unsigned AW = $clog2(TABLE_DEPTH);
   localparam int unsigned CW = AW + 1;
   localparam int unsigned MOD_STEPS = ohm_pkg::HASH_W;
   localparam int unsigned MW = (ohm_pkg::SIZE_W > CW) ? ohm_pkg::SIZE_W : CW;

   logic [ohm_pkg::SIZE_W-1:0] size_reg_ff;
   logic [CW-1:0] size_used;
   ohm_pkg::req_type req_ff;
   logic [ohm_pkg::KEY_W-1:0] mask_high, mask_low, kh, kl;
   logic [ohm_pkg::HASH_W-1:0] hash_value;
   logic [ohm_pkg::HASH_W-1:0] quot_ff;
   logic [CW-1:0] rem_ff;
   logic [CW:0] rem_shift;
   logic [5:0] mod_cnt_ff;
   logic [AW-1:0] idx_ff;
   logic [CW-1:0] probe_cnt_ff;
   logic [CW-1:0] sweep_ff;
   ohm_pkg::rsp_type rsp_ff;

   logic st_we;
   logic [AW-1:0] st_addr;
   logic [1:0] st_wdata, st_rdata;
   logic [ohm_pkg::KEY_W-1:0] kh_rd, kl_rd;
   logic [ohm_pkg::VALUE_W-1:0] val_rd;

   // clamp the size register into 1..TABLE_DEPTH
   always_comb begin
      if (size_reg_ff == '0) begin
         size_used = CW'(1);
      end else if (MW'(size_reg_ff) > MW'(TABLE_DEPTH)) begin
         size_used = CW'(TABLE_DEPTH);
      end else begin
         size_used = CW'(size_reg_ff);
      end
   end

   always_comb begin
      mask_high = '0;
      mask_low = '0;
      for (int i = 0; i < 16; i++) begin
         if (i < KEY_BYTES) begin
            if (i < 8) begin
               mask_low[8*i +: 8] = 8'hff;
            end else begin
               mask_high[8*(i-8) +: 8] = 8'hff;
            end
         end
      end
      kh = req_ff.key_high & mask_high;
      kl = req_ff.key_low & mask_low;
      hash_value = kl[31:0] ^ kl[63:32] ^ kh[31:0] ^ kh[63:32];
   end

   assign rem_shift = {rem_ff, quot_ff[ohm_pkg::HASH_W-1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         size_reg_ff <= ohm_pkg::SIZE_W'(256);
         sweep_ff <= '0;
      end else begin
         if (csr_valid) begin
            size_reg_ff <= csr_data;
         end
         if (cmd.sweep_init) begin
            sweep_ff <= '0;
         end else if (cmd.sweep_next) begin
            sweep_ff <= sweep_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_data;
      end
      if (cmd.hash_start) begin
         quot_ff <= hash_value;
         rem_ff <= '0;
         mod_cnt_ff <= '0;
      end else if (cmd.mod_step) begin
         // one restoring remainder bit a cycle
         quot_ff <= {quot_ff[ohm_pkg::HASH_W-2:0], 1'b0};
         mod_cnt_ff <= mod_cnt_ff + 6'd1;
         if (rem_shift >= {1'b0, size_used}) begin
            rem_ff <= CW'(rem_shift - {1'b0, size_used});
         end else begin
            rem_ff <= CW'(rem_shift);
         end
      end
      if (cmd.probe_init) begin
         if (rem_shift >= {1'b0, size_used}) begin
            idx_ff <= AW'(rem_shift - {1'b0, size_used});
         end else begin
            idx_ff <= AW'(rem_shift);
         end
         probe_cnt_ff <= CW'(1);
      end else if (cmd.probe_next) begin
         probe_cnt_ff <= probe_cnt_ff + CW'(1);
         if ({1'b0, idx_ff} + CW'(1) >= size_used) begin
            idx_ff <= '0;
         end else begin
            idx_ff <= idx_ff + AW'(1);
         end
      end
      if (cmd.set_result) begin
         rsp_ff.status <= cmd.result_status;
         rsp_ff.found_value <= cmd.take_value ? val_rd : '0;
      end
   end

   assign st_we = cmd.sweep_write || cmd.write_add || cmd.write_delete;
   assign st_addr = cmd.sweep_write ? sweep_ff[AW-1:0] : idx_ff;
   assign st_wdata = cmd.write_add ? ohm_pkg::SLOT_USED
                   : cmd.write_delete ? ohm_pkg::SLOT_DELETED : ohm_pkg::SLOT_EMPTY;

   ohm_ram #(.WIDTH(2), .DEPTH(TABLE_DEPTH)) u_status (
      .clock(clock), .we(st_we), .addr(st_addr), .wdata(st_wdata), .rdata(st_rdata));
   ohm_ram #(.WIDTH(ohm_pkg::KEY_W), .DEPTH(TABLE_DEPTH)) u_key_high (
      .clock(clock), .we(cmd.write_add), .addr(idx_ff), .wdata(kh), .rdata(kh_rd));
   ohm_ram #(.WIDTH(ohm_pkg::KEY_W), .DEPTH(TABLE_DEPTH)) u_key_low (
      .clock(clock), .we(cmd.write_add), .addr(idx_ff), .wdata(kl), .rdata(kl_rd));
   ohm_ram #(.WIDTH(ohm_pkg::VALUE_W), .DEPTH(TABLE_DEPTH)) u_value (
      .clock(clock), .we(cmd.write_add), .addr(idx_ff), .wdata(req_ff.entry_value),
      .rdata(val_rd));

   assign stat.kind = req_ff.kind;
   assign stat.mod_done = (mod_cnt_ff == 6'(MOD_STEPS - 1));
   assign stat.sweep_last = (sweep_ff == CW'(TABLE_DEPTH - 1));
   assign stat.probe_last = (probe_cnt_ff >= size_used);
   assign stat.slot_state = st_rdata;
   assign stat.key_match = (kh_rd == kh) && (kl_rd == kl);
   assign rsp_data = rsp_ff;

endmodule
